// File: hw/rtl/wim_pkg.sv
// Package for the window identity masker.
// Holds the field widths, register indexes, mask character and sequencer states.
// Depends on nothing; every other file of the block refers to it.
`timescale 1ns / 1ps
`default_nettype none

package wim_pkg;

    // Field widths fixed by the stream format.
    localparam int CHAR_W    = 8;
    localparam int WIN_REG_W = 7;
    localparam int THR_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;

    // Character written where the window identity is too low.
    localparam logic [CHAR_W-1:0] MASK_CHAR = 8'd78;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;

    // Reset values of the registers.
    localparam logic [WIN_REG_W-1:0] WIN_RESET = 7'd16;
    localparam logic [THR_W-1:0]     THR_RESET = 17'd0;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/wim_if.sv
// Channel interfaces of the window identity masker: input pairs, result words
// and configuration writes. Each carries valid, ready and its payload.
// Depends on wim_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wim_in_if;
    logic                        valid;
    logic                        ready;
    logic [wim_pkg::CHAR_W-1:0]  query_char;
    logic [wim_pkg::CHAR_W-1:0]  target_char;
    logic                        last_pos;

    modport source (output valid, output query_char, output target_char,
                    output last_pos, input ready);
    modport sink   (input valid, input query_char, input target_char,
                    input last_pos, output ready);
endinterface

interface wim_out_if;
    logic                        valid;
    logic                        ready;
    logic [wim_pkg::CHAR_W-1:0]  out_char;
    logic                        out_last;
    logic                        too_short;

    modport source (output valid, output out_char, output out_last,
                    output too_short, input ready);
    modport sink   (input valid, input out_char, input out_last,
                    input too_short, output ready);
endinterface

interface wim_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wim_pkg::CFG_IDX_W-1:0] reg_index;
    logic [wim_pkg::THR_W-1:0]     reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/window_identity_masker.sv
// Top level of the window identity masker: ring memory, sequencer and output register.
// Depends on wim_pkg and on the channel interfaces in wim_if.sv.
//
//   Channel  Port   Dir  Word
//   input    i_in   in   query_char, target_char, last_pos
//   result   o_out  out  out_char, out_last, too_short
//   config   i_cfg  in   reg_index, reg_data (window_len, threshold_q16)
//
// An accepted pair is written to the ring memory, then the sequencer enters its check state.
// Result words leave in the emit state while the output register is free or being taken.
// A window length lowered below the buffered count adds a scan step for each surplus entry.
// Reset is synchronous and active low; it clears the control state, not the ring memory.
// The output register lets a word wait for the sink while the block takes the next pair.
`timescale 1ns / 1ps
`default_nettype none

module window_identity_masker #(
    parameter int MAX_WINDOW = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    wim_in_if.sink      i_in,
    wim_out_if.source   o_out,
    wim_cfg_if.sink     i_cfg
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int PW = wim_pkg::THR_W + CW;
    localparam int EW = wim_pkg::CHAR_W + 1;

    // Ring offset with wrap at the memory depth; the sum stays below twice the depth.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(base) + (CW + 1)'(off);
        if (s >= (CW + 1)'(MAX_WINDOW)) begin
            s = s - (CW + 1)'(MAX_WINDOW);
        end
        return s[AW-1:0];
    endfunction

    // Configuration registers.
    logic [wim_pkg::WIN_REG_W-1:0] r_win;
    logic [wim_pkg::THR_W-1:0]     r_thr;

    // Sequencer and ring bookkeeping.
    wim_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_fill, n_fill;
    logic [CW-1:0]   r_mcnt, n_mcnt;
    logic [CW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_j, n_j;
    logic [CW-1:0]   r_k;
    logic            r_last;
    logic            r_short;

    // Ring memory: match bit over query character.
    logic [EW-1:0]   r_ring [MAX_WINDOW];
    logic [EW-1:0]   r_rd_a;
    logic            r_rd_b;
    logic [AW-1:0]   addr_a, addr_b, addr_w;

    // Output register.
    logic                        r_ovalid;
    logic [wim_pkg::CHAR_W-1:0]  r_ochar;
    logic                        r_olast;
    logic                        r_oshort;

    logic            in_fire, cfg_fire, emit_fire;
    logic [CW-1:0]   k_cfg, w_emit, cnt_emit;
    logic [PW-1:0]   lhs, rhs;
    logic            masked;

    assign in_fire   = i_in.valid && i_in.ready;
    assign cfg_fire  = i_cfg.valid && i_cfg.ready;
    assign i_in.ready = (r_state == wim_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Effective window: zero counts as one, larger values clamp to the depth.
    always_comb begin
        if (r_win == '0) begin
            k_cfg = CW'(1);
        end else if (r_win > wim_pkg::WIN_REG_W'(MAX_WINDOW)) begin
            k_cfg = CW'(MAX_WINDOW);
        end else begin
            k_cfg = CW'(r_win);
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= wim_pkg::WIN_RESET;
            r_thr <= wim_pkg::THR_RESET;
        end else if (cfg_fire) begin
            case (i_cfg.reg_index)
                wim_pkg::REG_WINDOW_LEN: r_win <= i_cfg.reg_data[wim_pkg::WIN_REG_W-1:0];
                wim_pkg::REG_THRESHOLD:  r_thr <= i_cfg.reg_data;
                default: ;
            endcase
        end
    end

    // Identity test of the oldest entry: count * 65536 < threshold * window.
    assign w_emit   = (r_fill < r_k) ? r_fill : r_k;
    assign cnt_emit = r_mcnt - r_tail;
    assign lhs      = PW'(cnt_emit) << wim_pkg::FRAC_W;
    assign rhs      = PW'(r_thr) * PW'(w_emit);
    assign masked   = !r_short && (lhs < rhs);

    assign emit_fire = (r_state == wim_pkg::S_EMIT) && (!r_ovalid || o_out.ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            wim_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = wim_pkg::S_CHECK;
                end
            end
            wim_pkg::S_CHECK: begin
                if (r_last || r_fill >= r_k) begin
                    n_state = (r_fill > r_k) ? wim_pkg::S_SCAN : wim_pkg::S_EMIT;
                end else begin
                    n_state = wim_pkg::S_IDLE;
                end
            end
            wim_pkg::S_SCAN: begin
                if ((r_j + CW'(1)) == r_fill) begin
                    n_state = wim_pkg::S_EMIT;
                end
            end
            wim_pkg::S_EMIT: begin
                if (emit_fire) begin
                    if (r_last) begin
                        n_state = (n_fill == '0) ? wim_pkg::S_IDLE : wim_pkg::S_EMIT;
                    end else begin
                        n_state = (n_fill >= r_k) ? wim_pkg::S_EMIT : wim_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = wim_pkg::S_IDLE;
        endcase
    end

    // Ring bookkeeping for the next cycle.
    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        n_mcnt = r_mcnt;
        n_tail = r_tail;
        n_j    = r_j;
        case (r_state)
            wim_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_fill = r_fill + CW'(1);
                    n_mcnt = r_mcnt + CW'(i_in.query_char == i_in.target_char);
                end
            end
            wim_pkg::S_CHECK: begin
                // Entries past the window are summed by the scan that follows.
                n_tail = '0;
                n_j    = r_k;
            end
            wim_pkg::S_SCAN: begin
                n_tail = r_tail + CW'(r_rd_b);
                n_j    = r_j + CW'(1);
            end
            wim_pkg::S_EMIT: begin
                if (emit_fire) begin
                    n_head = ring_add(r_head, CW'(1));
                    n_fill = r_fill - CW'(1);
                    n_mcnt = r_mcnt - CW'(r_rd_a[EW-1]);
                    // The entry just past the window slides into it.
                    if (r_fill > r_k) begin
                        n_tail = r_tail - CW'(r_rd_b);
                    end
                end
            end
            default: ;
        endcase
    end

    // Read addresses follow the next head, so read data lines up with the registered head.
    assign addr_w = ring_add(r_head, r_fill);
    assign addr_a = n_head;
    assign addr_b = (n_state == wim_pkg::S_SCAN) ? ring_add(r_head, n_j)
                                                 : ring_add(n_head, r_k);

    // Ring memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ring[addr_w] <= {i_in.query_char == i_in.target_char, i_in.query_char};
        end
        r_rd_a <= r_ring[addr_a];
        r_rd_b <= r_ring[addr_b][EW-1];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wim_pkg::S_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_mcnt  <= '0;
            r_tail  <= '0;
            r_j     <= '0;
            r_k     <= CW'(1);
            r_last  <= 1'b0;
            r_short <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_mcnt  <= n_mcnt;
            r_tail  <= n_tail;
            r_j     <= n_j;
            if (in_fire) begin
                r_k    <= k_cfg;
                r_last <= i_in.last_pos;
            end
            if (r_state == wim_pkg::S_CHECK) begin
                r_short <= r_last && (r_fill < r_k);
            end
        end
    end

    // Output register: holds a word until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit_fire) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_ochar  <= masked ? wim_pkg::MASK_CHAR : r_rd_a[wim_pkg::CHAR_W-1:0];
            r_olast  <= r_last && (r_fill == CW'(1));
            r_oshort <= r_short;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.out_char  = r_ochar;
    assign o_out.out_last  = r_olast;
    assign o_out.too_short = r_oshort;

    // The ring never holds more entries than its depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_WINDOW))
        else $error("ring fill count exceeds the depth");

    // Match totals never exceed the entries they are counted over.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mcnt <= r_fill) && (r_tail <= r_mcnt))
        else $error("match counters out of range");

    // Emitting the final word of a sequence leaves the ring empty.
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && r_last && r_fill == CW'(1)) |=> (r_fill == '0 && r_mcnt == '0))
        else $error("ring not empty after the final word");

    // A pair is only taken when no word is being produced.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == wim_pkg::S_CHECK && !emit_fire))
        else $error("pair taken while the sequencer was busy");

endmodule

`default_nettype wire

// File: verif/window_identity_masker_tb.sv
// Testbench for the window identity masker: directed pairs, then random phases.
// Predicts every result word with a ring model of the block and checks each field.
// Depends on wim_pkg, on the channel interfaces in wim_if.sv and on the top level.
`timescale 1ns / 1ps

import wim_pkg::*;

localparam int RING_DEPTH = 64;

// One expected or observed result word.
typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              too_short;
} t_mask_word;

class mask_scoreboard;
    bit [CHAR_W-1:0]    query_store [RING_DEPTH];
    bit                 match_store [RING_DEPTH];
    int unsigned        head;
    int unsigned        fill;
    bit [WIN_REG_W-1:0] win_reg;
    bit [THR_W-1:0]     thr_reg;
    t_mask_word         pending_words[$];
    int unsigned        errors;
    int unsigned        checked;

    function new();
        win_reg = WIN_RESET;
        thr_reg = THR_RESET;
        head    = 0;
        fill    = 0;
        errors  = 0;
        checked = 0;
    endfunction

    function int unsigned pending();
        return pending_words.size();
    endfunction

    // A window-length write takes the low bits of the data word only; a threshold write takes all of it.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
        case (idx)
            REG_WINDOW_LEN: win_reg = data[WIN_REG_W-1:0];
            REG_THRESHOLD:  thr_reg = data;
            default: ;
        endcase
    endfunction

    // Zero acts as a window of one, and anything above the ring depth is clamped.
    function int unsigned active_window();
        if (win_reg == 0) begin
            return 1;
        end
        if (win_reg > RING_DEPTH) begin
            return RING_DEPTH;
        end
        return win_reg;
    endfunction

    // Judge the oldest buffered pair over a window of size w, then drop it.
    function void judge_oldest(int unsigned w, bit flag_short, bit is_last);
        int unsigned     cnt;
        longint unsigned lhs;
        longint unsigned rhs;
        t_mask_word      word;
        cnt = 0;
        for (int unsigned j = 0; j < w && j < fill; j++) begin
            cnt += match_store[(head + j) % RING_DEPTH];
        end
        word.ch        = query_store[head];
        word.last      = is_last;
        word.too_short = flag_short;
        lhs = longint'(cnt) * 64'd65536;
        rhs = longint'(thr_reg) * longint'(w);
        if (!flag_short && lhs < rhs) begin
            word.ch = MASK_CHAR;
        end
        pending_words.push_back(word);
        head = (head + 1) % RING_DEPTH;
        fill--;
    endfunction

    // Buffer one accepted pair and predict the words that it releases.
    function void predict_pair(logic [CHAR_W-1:0] q, logic [CHAR_W-1:0] t, logic last);
        int unsigned k;
        bit          short_seq;
        k = active_window();
        query_store[(head + fill) % RING_DEPTH] = q;
        match_store[(head + fill) % RING_DEPTH] = (q == t);
        fill++;
        if (!last) begin
            while (fill >= k) begin
                judge_oldest(k, 1'b0, 1'b0);
            end
        end else begin
            short_seq = (fill < k);
            while (fill > 0) begin
                judge_oldest((fill < k) ? fill : k, short_seq, fill == 1);
            end
        end
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_word(logic [CHAR_W-1:0] ch, logic last, logic too_short);
        t_mask_word exp_w;
        if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: char %0d last %0b too_short %0b",
                     $time, ch, last, too_short);
            return;
        end
        exp_w = pending_words.pop_front();
        checked++;
        if (ch !== exp_w.ch) begin
            errors++;
            $display("%0t: out_char expected %0d actual %0d", $time, exp_w.ch, ch);
        end
        if (last !== exp_w.last) begin
            errors++;
            $display("%0t: out_last expected %0b actual %0b", $time, exp_w.last, last);
        end
        if (too_short !== exp_w.too_short) begin
            errors++;
            $display("%0t: too_short expected %0b actual %0b",
                     $time, exp_w.too_short, too_short);
        end
    endfunction
endclass

module window_identity_masker_tb;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 2;
    localparam int SETTLE_CYCLES = 100;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 330;
    localparam int PHASES        = 8;
    localparam int MAX_SEQ_LEN   = 80;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [CHAR_W-1:0]    GAP_CHAR  = 8'd45;

    logic clk;
    logic rst_n;

    wim_in_if  in_ch ();
    wim_out_if out_ch ();
    wim_cfg_if cfg_ch ();

    mask_scoreboard sb = new();

    int unsigned in_idle_pct;
    int unsigned out_stall_pct;
    int unsigned pairs_sent;
    int unsigned cfg_writes;

    window_identity_masker #(
        .MAX_WINDOW(RING_DEPTH)
    ) u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Receiver: ready changes at the falling edge, stalling at the current rate.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // Every accepted result word is checked at the rising edge.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_word(out_ch.out_char, out_ch.out_last, out_ch.too_short);
        end
    end

    // Watchdog: ends the run when no channel moves a word for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Send one pair, with random idle cycles ahead of it. Entered and left at a falling edge.
    task automatic send_pair(logic [CHAR_W-1:0] q, logic [CHAR_W-1:0] t, logic last);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.query_char  <= q;
        in_ch.target_char <= t;
        in_ch.last_pos    <= last;
        do @(posedge clk); while (!in_ch.ready);
        sb.predict_pair(q, t, last);
        pairs_sent++;
        @(negedge clk);
    endtask

    // One register write; valid stays high so that writes can follow back to back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.reg_data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_reg(idx, data);
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic configure(logic [THR_W-1:0] win_data, logic [THR_W-1:0] thr_data);
        write_reg(REG_WINDOW_LEN, win_data);
        write_reg(REG_THRESHOLD, thr_data);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every expected word has arrived, then let the block go quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // A sequence of random pairs where the target matches the query at about match_pct.
    task automatic send_sequence(int unsigned len, int unsigned match_pct);
        logic [CHAR_W-1:0] q;
        logic [CHAR_W-1:0] t;
        for (int unsigned i = 0; i < len; i++) begin
            q = ($urandom_range(0, 9) == 0) ? GAP_CHAR : CHAR_W'($urandom_range(0, 255));
            t = ($urandom_range(0, 99) < match_pct) ? q : CHAR_W'($urandom_range(0, 255));
            send_pair(q, t, i == len - 1);
        end
    endtask

    initial begin : stimulus
        logic [WIN_REG_W-1:0] win;
        logic [THR_W-1:0]     win_data;
        logic [THR_W-1:0]     thr;
        int unsigned          eff_win;
        int unsigned          thr_pct;
        int                   pct;
        int unsigned          len;
        int unsigned          phase_end;

        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.query_char   = '0;
        in_ch.target_char  = '0;
        in_ch.last_pos     = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = '0;
        cfg_ch.reg_data    = '0;
        in_idle_pct        = 0;
        out_stall_pct      = 0;
        pairs_sent         = 0;
        cfg_writes         = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: window of 16, so three pairs form a short sequence.
        send_pair(8'h00, 8'h00, 1'b0);
        send_pair(8'hFF, 8'h00, 1'b0);
        send_pair(8'hFF, 8'hFF, 1'b1);
        settle();

        // A write to the spare index is ignored; a zero window acts as one.
        write_reg(REG_SPARE, 17'h1FFFF);
        configure(17'd0, 17'd65536);
        send_pair(8'h41, 8'h41, 1'b0);
        send_pair(GAP_CHAR, GAP_CHAR, 1'b0);
        send_pair(8'h80, 8'h7F, 1'b1);
        settle();

        // Window lowered while pairs are still buffered in the middle of a sequence.
        configure(17'd4, 17'd32768);
        send_pair(8'h01, 8'h01, 1'b0);
        send_pair(8'h02, 8'h09, 1'b0);
        send_pair(8'h03, 8'h03, 1'b0);
        settle();
        configure(17'd2, 17'd32768);
        send_pair(8'h04, 8'h04, 1'b0);
        send_pair(8'h05, 8'h06, 1'b1);
        settle();

        // Threshold above one: every position is masked even with all pairs equal.
        configure(17'd3, 17'h1FFFF);
        send_pair(8'h55, 8'h55, 1'b0);
        send_pair(8'hAA, 8'hAA, 1'b0);
        send_pair(8'h7F, 8'h7F, 1'b0);
        send_pair(8'h80, 8'h80, 1'b1);
        settle();

        // Window beyond the ring depth is clamped, so five pairs are too short.
        configure(17'd100, 17'd0);
        send_pair(8'h10, 8'h20, 1'b0);
        send_pair(8'h30, 8'h30, 1'b0);
        send_pair(8'hFE, 8'h01, 1'b0);
        send_pair(8'h00, 8'hFF, 1'b0);
        send_pair(8'h99, 8'h99, 1'b1);
        settle();

        // Random phases, each with its own settings and idling.
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 72; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 72; end
                default: begin in_idle_pct = 20; out_stall_pct = 20; end
            endcase
            case (phase)
                0: begin win = 7'd1;   thr = 17'd0;      end
                1: begin win = 7'd64;  thr = 17'd65536;  end
                2: begin win = 7'd127; thr = 17'h1FFFF;  end
                3: begin win = 7'd0;   thr = THR_W'($urandom_range(0, 131071)); end
                default: begin
                    win = WIN_REG_W'($urandom_range(2, 24));
                    thr = THR_W'($urandom_range(0, 65536));
                end
            endcase
            win_data = THR_W'($urandom_range(0, 131071));
            win_data[WIN_REG_W-1:0] = win;
            configure(win_data, thr);

            eff_win = (win == 0) ? 1 : ((win > RING_DEPTH) ? RING_DEPTH : win);
            thr_pct = (thr * 100) / 65536;
            if (thr_pct > 100) begin
                thr_pct = 100;
            end
            phase_end = pairs_sent + RANDOM_ITEMS / PHASES;
            while (pairs_sent < phase_end) begin
                len = $urandom_range(1, eff_win * 2 + 2);
                if (len > MAX_SEQ_LEN) begin
                    len = MAX_SEQ_LEN;
                end
                // The last sequence of a phase is cut to the pairs the phase has left.
                if (len > phase_end - pairs_sent) begin
                    len = phase_end - pairs_sent;
                end
                // Mostly near the threshold, sometimes arbitrary content.
                if ($urandom_range(0, 4) == 0) begin
                    pct = $urandom_range(0, 100);
                end else begin
                    pct = int'(thr_pct) + int'($urandom_range(0, 50)) - 25;
                end
                if (pct < 0) begin
                    pct = 0;
                end
                if (pct > 100) begin
                    pct = 100;
                end
                send_sequence(len, pct);
            end
            settle();
        end

        if (sb.pending() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, sb.pending());
        end
        $display("Run covered %0d pairs, %0d checked words and %0d register writes,",
                 pairs_sent, sb.checked, cfg_writes);
        $display("over directed cases and %0d random phases with varied idling.", PHASES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: window_identity_masker.f
hw/rtl/wim_pkg.sv
hw/rtl/wim_if.sv
hw/rtl/window_identity_masker.sv
verif/window_identity_masker_tb.sv
